@@ hw/rtl/acc_pkg.sv @@
// Shared types and constants of the assist current controller.
// Depends on nothing; all files but acc_checker refer to it by scoped names.
package acc_pkg;

   // Field widths
   localparam int unsigned CUR_W    = 16;
   localparam int unsigned CMD_W    = 17;
   localparam int unsigned FILT_W   = 18;
   localparam int unsigned TARGET_W = 17;
   localparam int unsigned NUM_W    = 32;
   localparam int unsigned DEN_W    = 16;
   localparam int unsigned CNT_W    = 6;
   localparam int unsigned GEARS    = 6;

   // Numerator padding so that the significant bits sit at the top of the divider
   localparam int unsigned PHASE_PAD_W = NUM_W - TARGET_W;

   // Support modes
   localparam logic [1:0] MODE_PEDAL  = 2'd1;
   localparam logic [1:0] MODE_TORQUE = 2'd2;

   // Arithmetic constants: duty floor of 0.02 in Q15, ramp of 1.5 A
   localparam logic signed [15:0] DUTY_FLOOR = 16'sd655;
   localparam logic [FILT_W-1:0]  RAMP_LIMIT = 18'd384;
   localparam logic [5:0]         GEAR_LAST  = 6'd6;

   // A tenth is taken by multiplying with ceil(2^20 / 10) and dropping 20 bits.
   // This is exact for every magnitude below 2^18.
   localparam logic [16:0]        TENTH_MULT = 17'd104858;

   // Divider pass length: a full quotient for the phase current
   localparam logic [CNT_W-1:0] PHASE_ITERS = 6'd32;

   // Register map
   typedef enum logic [2:0] {
      REG_GEAR_ONE,
      REG_GEAR_TWO,
      REG_GEAR_THREE,
      REG_GEAR_FOUR,
      REG_GEAR_FIVE,
      REG_GEAR_SIX,
      REG_LIMIT_LOW,
      REG_LIMIT_HIGH
   } reg_index_type;

   // Reset values of the registers
   localparam logic [GEARS-1:0][CUR_W-1:0] GEAR_RESET = {
      16'd12800, 16'd7680, 16'd3840, 16'd2304, 16'd1280, 16'd640
   };
   localparam logic signed [CMD_W-1:0] LIMIT_LOW_RESET  = -17'sd15360;
   localparam logic [CUR_W-1:0]        LIMIT_HIGH_RESET = 16'd15360;

   typedef struct packed {
      logic [GEARS-1:0][CUR_W-1:0] gear_current;
      logic signed [CMD_W-1:0]     limit_low;
      logic [CUR_W-1:0]            limit_high;
   } cfg_type;

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] iters;
   } div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TARGET,
      ST_DIV_PHASE,
      ST_CLAMP,
      ST_DIFF,
      ST_DIV_FILT,
      ST_UPDATE
   } state_type;

endpackage

@@ hw/rtl/assist_current_controller_top.sv @@
// An accepted request runs through TARGET, DIV_PHASE, CLAMP, DIFF, DIV_FILT and UPDATE;
// with the motor off it goes from TARGET straight to UPDATE. Most of the time goes to the
// restoring divider, 32 steps for the phase current; the 1/10 filter step is a reciprocal
// multiplication in a cycle of its own.
// One request is in progress at a time; a finished result waits in the output register.
// Synchronous reset clears the sequencer, the filtered current and the output valid,
// and loads the register defaults; a request is taken in the first cycle after reset.
module assist_current_controller_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_motor_enabled,
   input  logic [1:0]         req_assist_mode,
   input  logic               req_pedaling,
   input  logic [15:0]        req_torque_fraction,
   input  logic [2:0]         req_gear,
   input  logic signed [15:0] req_duty_now,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [16:0] rsp_current_command,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   acc_pkg::cfg_type        cfg;
   acc_pkg::div_cmd_type    div_cmd;
   acc_pkg::div_status_type div_status;
   logic [acc_pkg::NUM_W-1:0] div_num;
   logic [acc_pkg::DEN_W-1:0] div_den;
   logic [acc_pkg::NUM_W-1:0] div_quot;

   acc_pkg::state_type state_ff, state_in;

   // Captured request
   logic               en_ff;
   logic [1:0]         mode_ff;
   logic               pedal_ff;
   logic [15:0]        torque_ff;
   logic [2:0]         gear_ff;
   logic signed [15:0] duty_ff;

   logic [acc_pkg::FILT_W-1:0] filt_ff, filt_in;
   logic [acc_pkg::CMD_W-1:0]  phase_ff, phase_in;
   logic                       neg_ff, neg_in;
   logic [acc_pkg::FILT_W-1:0] mag_ff, mag_in;
   logic [acc_pkg::FILT_W-1:0] tenth_ff, tenth_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [acc_pkg::CMD_W-1:0]  rsp_cmd_ff, rsp_cmd_in;

   logic                           accept;
   logic                           out_free;
   logic                           gear_ok;
   logic [2:0]                     gear_idx;
   logic [acc_pkg::CUR_W-1:0]      gear_cur;
   logic [31:0]                    product;
   logic [acc_pkg::TARGET_W-1:0]   target;
   logic signed [15:0]             duty_eff;
   logic signed [32:0]             quot_s;
   logic signed [32:0]             low_s;
   logic [acc_pkg::FILT_W-1:0]     diff;
   logic [acc_pkg::FILT_W-1:0]     mag;
   logic [34:0]                    tenth_prod;
   logic [acc_pkg::FILT_W-1:0]     step;
   logic [acc_pkg::FILT_W-1:0]     filt_next;

   acc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   acc_div u_div (
      .clock  (clock),
      .reset  (reset),
      .cmd    (div_cmd),
      .num    (div_num),
      .den    (div_den),
      .status (div_status),
      .quot   (div_quot)
   );

   assign req_stall           = (state_ff != acc_pkg::ST_IDLE);
   assign accept              = req_valid & ~req_stall;
   assign out_free            = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_current_command = $signed(rsp_cmd_ff);

   // Target current from the gear table and the support mode
   always_comb begin
      gear_ok  = (gear_ff != 3'd0) && ({3'd0, gear_ff} <= acc_pkg::GEAR_LAST);
      gear_idx = gear_ff - 3'd1;
      gear_cur = gear_ok ? cfg.gear_current[gear_idx] : '0;
      product  = torque_ff * gear_cur;
      case (mode_ff)
         acc_pkg::MODE_PEDAL:  target = pedal_ff ? {1'b0, gear_cur} : '0;
         acc_pkg::MODE_TORQUE: target = product[31:15];
         default:              target = '0;
      endcase
      duty_eff = (duty_ff < acc_pkg::DUTY_FLOOR) ? acc_pkg::DUTY_FLOOR : duty_ff;
   end

   // Clamp, filter difference and ramp-limited step
   always_comb begin
      quot_s     = $signed({1'b0, div_quot});
      low_s      = $signed({{16{cfg.limit_low[16]}}, cfg.limit_low});
      diff       = {phase_ff[acc_pkg::CMD_W-1], phase_ff} - filt_ff;
      mag        = diff[acc_pkg::FILT_W-1] ? (18'd0 - diff) : diff;
      tenth_prod = mag_ff * acc_pkg::TENTH_MULT;
      if (neg_ff) begin
         step = 18'd0 - tenth_ff;
      end else if (tenth_ff > acc_pkg::RAMP_LIMIT) begin
         step = acc_pkg::RAMP_LIMIT;
      end else begin
         step = tenth_ff;
      end
      filt_next = filt_ff + step;
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      filt_in      = filt_ff;
      phase_in     = phase_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      tenth_in     = tenth_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_cmd_in   = rsp_cmd_ff;
      div_cmd      = '0;
      div_num      = '0;
      div_den      = '0;
      case (state_ff)
         acc_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = acc_pkg::ST_TARGET;
            end
         end
         acc_pkg::ST_TARGET: begin
            if (!en_ff) begin
               state_in = acc_pkg::ST_UPDATE;
            end else begin
               // A zero target restarts the filter from zero
               if (target == '0) begin
                  filt_in = '0;
               end
               div_cmd.start = 1'b1;
               div_cmd.iters = acc_pkg::PHASE_ITERS;
               div_num       = {target, {acc_pkg::PHASE_PAD_W{1'b0}}};
               div_den       = $unsigned(duty_eff);
               state_in      = acc_pkg::ST_DIV_PHASE;
            end
         end
         acc_pkg::ST_DIV_PHASE: begin
            if (div_status.done) begin
               state_in = acc_pkg::ST_CLAMP;
            end
         end
         acc_pkg::ST_CLAMP: begin
            // The low limit is tested first, so a quotient below it takes the low
            // limit even when the limits cross
            if (quot_s < low_s) begin
               phase_in = cfg.limit_low;
            end else if (div_quot > {16'd0, cfg.limit_high}) begin
               phase_in = {1'b0, cfg.limit_high};
            end else begin
               phase_in = div_quot[acc_pkg::CMD_W-1:0];
            end
            state_in = acc_pkg::ST_DIFF;
         end
         acc_pkg::ST_DIFF: begin
            // Keep the magnitude and put the sign back after the division by ten
            neg_in   = diff[acc_pkg::FILT_W-1];
            mag_in   = mag;
            state_in = acc_pkg::ST_DIV_FILT;
         end
         acc_pkg::ST_DIV_FILT: begin
            // A tenth of the magnitude, rounded down
            tenth_in = {3'b000, tenth_prod[34:20]};
            state_in = acc_pkg::ST_UPDATE;
         end
         acc_pkg::ST_UPDATE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (en_ff) begin
                  filt_in    = filt_next;
                  rsp_cmd_in = filt_next[acc_pkg::CMD_W-1:0];
               end else begin
                  rsp_cmd_in = '0;
               end
               state_in = acc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = acc_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= acc_pkg::ST_IDLE;
         filt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         filt_ff      <= filt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      phase_ff   <= phase_in;
      neg_ff     <= neg_in;
      mag_ff     <= mag_in;
      tenth_ff   <= tenth_in;
      rsp_cmd_ff <= rsp_cmd_in;
      if (accept) begin
         en_ff     <= req_motor_enabled;
         mode_ff   <= req_assist_mode;
         pedal_ff  <= req_pedaling;
         torque_ff <= req_torque_fraction;
         gear_ff   <= req_gear;
         duty_ff   <= req_duty_now;
      end
   end

endmodule

@@ hw/rtl/acc_csr.sv @@
// Configuration registers of the assist current controller behind an APB-style port.
// Depends on acc_pkg for the register map, reset values and the configuration struct.
module acc_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [4:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output acc_pkg::cfg_type     cfg
);

   acc_pkg::cfg_type       cfg_ff;
   acc_pkg::cfg_type       cfg_in;
   acc_pkg::reg_index_type index;
   logic                   write_en;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite;
   assign index      = acc_pkg::reg_index_type'(csr_paddr[4:2]);
   assign cfg        = cfg_ff;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            acc_pkg::REG_GEAR_ONE:   cfg_in.gear_current[0] = csr_pwdata[15:0];
            acc_pkg::REG_GEAR_TWO:   cfg_in.gear_current[1] = csr_pwdata[15:0];
            acc_pkg::REG_GEAR_THREE: cfg_in.gear_current[2] = csr_pwdata[15:0];
            acc_pkg::REG_GEAR_FOUR:  cfg_in.gear_current[3] = csr_pwdata[15:0];
            acc_pkg::REG_GEAR_FIVE:  cfg_in.gear_current[4] = csr_pwdata[15:0];
            acc_pkg::REG_GEAR_SIX:   cfg_in.gear_current[5] = csr_pwdata[15:0];
            acc_pkg::REG_LIMIT_LOW:  cfg_in.limit_low       = csr_pwdata[16:0];
            acc_pkg::REG_LIMIT_HIGH: cfg_in.limit_high      = csr_pwdata[15:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // Register storage with reset defaults
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gear_current <= acc_pkg::GEAR_RESET;
         cfg_ff.limit_low    <= acc_pkg::LIMIT_LOW_RESET;
         cfg_ff.limit_high   <= acc_pkg::LIMIT_HIGH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read-back; the low limit is sign extended
   always_comb begin
      case (index)
         acc_pkg::REG_GEAR_ONE:   csr_prdata = {16'd0, cfg_ff.gear_current[0]};
         acc_pkg::REG_GEAR_TWO:   csr_prdata = {16'd0, cfg_ff.gear_current[1]};
         acc_pkg::REG_GEAR_THREE: csr_prdata = {16'd0, cfg_ff.gear_current[2]};
         acc_pkg::REG_GEAR_FOUR:  csr_prdata = {16'd0, cfg_ff.gear_current[3]};
         acc_pkg::REG_GEAR_FIVE:  csr_prdata = {16'd0, cfg_ff.gear_current[4]};
         acc_pkg::REG_GEAR_SIX:   csr_prdata = {16'd0, cfg_ff.gear_current[5]};
         acc_pkg::REG_LIMIT_LOW:  csr_prdata = {{15{cfg_ff.limit_low[16]}}, cfg_ff.limit_low};
         acc_pkg::REG_LIMIT_HIGH: csr_prdata = {16'd0, cfg_ff.limit_high};
         default:                 csr_prdata = 32'd0;
      endcase
   end

endmodule

@@ hw/rtl/acc_div.sv @@
// Restoring divider, one quotient bit per cycle, used for the phase current division.
// Depends on acc_pkg for the command and status structs and the widths.
module acc_div (
   input  logic                          clock,
   input  logic                          reset,
   input  acc_pkg::div_cmd_type          cmd,
   input  logic [acc_pkg::NUM_W-1:0]     num,
   input  logic [acc_pkg::DEN_W-1:0]     den,
   output acc_pkg::div_status_type       status,
   output logic [acc_pkg::NUM_W-1:0]     quot
);

   logic [acc_pkg::NUM_W-1:0] num_ff, num_in;
   logic [acc_pkg::DEN_W-1:0] rem_ff, rem_in;
   logic [acc_pkg::DEN_W-1:0] den_ff, den_in;
   logic [acc_pkg::CNT_W-1:0] count_ff, count_in;
   logic                      done_ff, done_in;
   logic [acc_pkg::DEN_W:0]   trial;
   logic [acc_pkg::DEN_W+1:0] diff;
   logic                      fits;

   // One restoring step: shift in the next numerator bit and try the subtraction
   always_comb begin
      trial = {rem_ff, num_ff[acc_pkg::NUM_W-1]};
      diff  = {1'b0, trial} - {2'b00, den_ff};
      fits  = ~diff[acc_pkg::DEN_W+1];
   end

   // Load on start, otherwise iterate until the count runs out
   always_comb begin
      num_in   = num_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      if (cmd.start) begin
         num_in   = num;
         rem_in   = '0;
         den_in   = den;
         count_in = cmd.iters;
      end else if (count_ff != '0) begin
         num_in   = {num_ff[acc_pkg::NUM_W-2:0], fits};
         rem_in   = fits ? diff[acc_pkg::DEN_W-1:0] : trial[acc_pkg::DEN_W-1:0];
         count_in = count_ff - 1'b1;
         done_in  = (count_ff == 6'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign status.busy = (count_ff != '0);
   assign status.done = done_ff;
   assign quot        = num_ff;

endmodule

@@ hw/rtl/acc_checker.sv @@
// Port-level checks of the assist current controller, bound to the top level.
// Depends only on the top level's ports.
module acc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [16:0] rsp_current_command
);

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // A stalled result keeps its value
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_current_command))
      else $error("result changed while stalled");

   // Only one request is worked on at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while one is in progress");

   // Reset leaves no result pending and the block ready
   a_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind assist_current_controller_top acc_checker u_acc_checker (.*);

@@ tb/assist_current_controller_top_test.sv @@
// Self-checking testbench for the assist current controller: a table of directed requests,
// then random control ticks over several register settings, each result checked against
// an in-bench predictor or a fixed command; needs acc_pkg, assist_current_controller_top.
`timescale 1ns / 1ps

module assist_current_controller_top_test;

   // Support modes that give no assist, named here as the package leaves them out.
   localparam logic [1:0] MODE_NONE  = 2'd0;
   localparam logic [1:0] MODE_SPARE = 2'd3;

   // Fixed-point constants of the control law.
   localparam longint DUTY_MIN     = 655;
   localparam longint RAMP_STEP    = 384;
   localparam longint FILTER_TAPS  = 10;

   localparam int unsigned SETTLE_CYCLES = 64;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned RANDOM_TICKS  = 100;
   localparam longint      CYCLE_LIMIT   = 400000;

   typedef struct packed {
      logic               motor_enabled;
      logic [1:0]         assist_mode;
      logic               pedaling;
      logic [15:0]        torque_fraction;
      logic [2:0]         gear;
      logic signed [15:0] duty_now;
   } tick_type;

   typedef struct packed {
      bit                 fixed;
      logic signed [16:0] command;
      tick_type           tick;
   } tick_row_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_motor_enabled;
   logic [1:0]         req_assist_mode;
   logic               req_pedaling;
   logic [15:0]        req_torque_fraction;
   logic [2:0]         req_gear;
   logic signed [15:0] req_duty_now;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [16:0] rsp_current_command;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [4:0]         csr_paddr;
   logic [31:0]        csr_pwdata;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   // Predictor state and its copy of the registers.
   longint gear_amps [1:6];
   longint limit_low;
   longint limit_high;
   longint filtered_amps;

   logic signed [16:0] command_queue [$];

   int     error_count;
   int     request_count;
   int     setting_count;
   int     motor_off_count;
   int     clear_count;
   int     ramp_count;
   longint cycle_count;
   bit     steady;
   bit     hold_request;

   // Persistent riding conditions, so that the filter gets several ticks to settle.
   logic [2:0]  run_gear;
   logic [1:0]  run_mode;
   int          run_duty;

   // Directed requests, issued with the reset register values.
   // Columns: fixed, command, enabled, mode, pedaling, torque, gear, duty.
   tick_row_type directed_rows [0:22] = '{
      // Motor off with every other field at its top.
      '{1'b1, 17'sd0, '{1'b0, acc_pkg::MODE_TORQUE, 1'b1, 16'hFFFF, 3'd6, 16'sh7FFF}},
      // Modes that give no assist.
      '{1'b1, 17'sd0, '{1'b1, MODE_NONE,            1'b1, 16'h8000, 3'd6, 16'sh7FFF}},
      '{1'b1, 17'sd0, '{1'b1, MODE_SPARE,           1'b1, 16'h8000, 3'd6, 16'sh7FFF}},
      // Pedal mode without pedaling, with gear zero and with the undefined gear seven.
      '{1'b1, 17'sd0, '{1'b1, acc_pkg::MODE_PEDAL,  1'b0, 16'h0000, 3'd6, 16'sh7FFF}},
      '{1'b1, 17'sd0, '{1'b1, acc_pkg::MODE_PEDAL,  1'b1, 16'h0000, 3'd0, 16'sh7FFF}},
      '{1'b1, 17'sd0, '{1'b1, acc_pkg::MODE_PEDAL,  1'b1, 16'h0000, 3'd7, 16'sh7FFF}},
      // Pedal assist at full duty, then a large gear that hits the ramp limit.
      '{1'b0, 17'sd0, '{1'b1, acc_pkg::MODE_PEDAL,  1'b1, 16'h0000, 3'd1, 16'sh7FFF}},
      '{1'b0, 17'sd0, '{1'b1, acc_pkg::MODE_PEDAL,  1'b1, 16'h0000, 3'd6, 16'sh7FFF}},
      '{1'b0, 17'sd0, '{1'b1, acc_pkg::MODE_PEDAL,  1'b1, 16'h0000, 3'd6, 16'sh7FFF}},
      // Duty at its most negative, at zero and on either side of the floor.
      '{1'b0, 17'sd0, '{1'b1, acc_pkg::MODE_PEDAL,  1'b1, 16'h0000, 3'd6, 16'sh8000}},
      '{1'b0, 17'sd0, '{1'b1, acc_pkg::MODE_PEDAL,  1'b1, 16'h0000, 3'd3, 16'sh0000}},
      '{1'b0, 17'sd0, '{1'b1, acc_pkg::MODE_PEDAL,  1'b1, 16'h0000, 3'd3, 16'sd654}},
      '{1'b0, 17'sd0, '{1'b1, acc_pkg::MODE_PEDAL,  1'b1, 16'h0000, 3'd3, 16'sd655}},
      // Torque mode: zero torque clears, one and above one, and a target lost to rounding.
      '{1'b1, 17'sd0, '{1'b1, acc_pkg::MODE_TORQUE, 1'b1, 16'h0000, 3'd6, 16'sh7FFF}},
      '{1'b0, 17'sd0, '{1'b1, acc_pkg::MODE_TORQUE, 1'b1, 16'h8000, 3'd6, 16'sd16384}},
      '{1'b0, 17'sd0, '{1'b1, acc_pkg::MODE_TORQUE, 1'b0, 16'hFFFF, 3'd6, 16'sh7FFF}},
      '{1'b1, 17'sd0, '{1'b1, acc_pkg::MODE_TORQUE, 1'b1, 16'h0001, 3'd1, 16'sh7FFF}},
      // Motor off between two ticks must leave the filtered current alone.
      '{1'b0, 17'sd0, '{1'b1, acc_pkg::MODE_TORQUE, 1'b1, 16'h4000, 3'd4, 16'sd8000}},
      '{1'b1, 17'sd0, '{1'b0, acc_pkg::MODE_PEDAL,  1'b1, 16'h0000, 3'd4, 16'sd8000}},
      '{1'b0, 17'sd0, '{1'b1, acc_pkg::MODE_TORQUE, 1'b1, 16'h4000, 3'd4, 16'sd8000}},
      // A fall, which is not ramp limited, and alternating bit patterns.
      '{1'b0, 17'sd0, '{1'b1, acc_pkg::MODE_PEDAL,  1'b1, 16'h5555, 3'd2, 16'sh7FFF}},
      '{1'b0, 17'sd0, '{1'b1, acc_pkg::MODE_TORQUE, 1'b1, 16'hAAAA, 3'd5, 16'sh7FFF}},
      '{1'b0, 17'sd0, '{1'b1, acc_pkg::MODE_PEDAL,  1'b1, 16'hFFFF, 3'd5, 16'shFFFF}}
   };

   assist_current_controller_top u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_motor_enabled   (req_motor_enabled),
      .req_assist_mode     (req_assist_mode),
      .req_pedaling        (req_pedaling),
      .req_torque_fraction (req_torque_fraction),
      .req_gear            (req_gear),
      .req_duty_now        (req_duty_now),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_current_command (rsp_current_command),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   always #1 clock = ~clock;

   // Works out the command of one tick and advances the filtered current.
   function automatic logic signed [16:0] next_current_command(tick_type tick);
      longint selected;
      longint target;
      longint duty;
      longint phase;
      longint step;
      if (!tick.motor_enabled) begin
         motor_off_count++;
         return '0;
      end
      selected = (tick.gear >= 3'd1 && tick.gear <= 3'd6) ? gear_amps[tick.gear] : 0;
      target = 0;
      if (tick.assist_mode == acc_pkg::MODE_PEDAL) begin
         target = tick.pedaling ? selected : 0;
      end else if (tick.assist_mode == acc_pkg::MODE_TORQUE) begin
         target = (longint'(tick.torque_fraction) * selected) >>> 15;
      end
      if (target == 0) begin
         filtered_amps = 0;
         clear_count++;
      end
      duty = longint'(tick.duty_now);
      if (duty < DUTY_MIN) begin
         duty = DUTY_MIN;
      end
      phase = (target <<< 15) / duty;
      if (phase < limit_low) begin
         phase = limit_low;
      end else if (phase > limit_high) begin
         phase = limit_high;
      end
      // Signed division truncates toward zero, as the filter requires.
      step = (phase - filtered_amps) / FILTER_TAPS;
      if (step > RAMP_STEP) begin
         step = RAMP_STEP;
         ramp_count++;
      end
      filtered_amps = filtered_amps + step;
      return filtered_amps[16:0];
   endfunction

   // Draws a tick: mostly steady riding with random detail, some pure noise.
   function automatic tick_type random_tick();
      tick_type tick;
      int       duty;
      if ($urandom_range(99) < 10) begin
         tick.motor_enabled   = 1'($urandom);
         tick.assist_mode     = 2'($urandom);
         tick.pedaling        = 1'($urandom);
         tick.torque_fraction = 16'($urandom);
         tick.gear            = 3'($urandom);
         tick.duty_now        = 16'($urandom);
         return tick;
      end
      if ($urandom_range(99) < 15) begin
         run_gear = ($urandom_range(9) == 0) ? 3'($urandom) : 3'($urandom_range(1, 6));
         run_mode = ($urandom_range(9) == 0) ? 2'($urandom) :
                    ($urandom_range(1) ? acc_pkg::MODE_PEDAL : acc_pkg::MODE_TORQUE);
         run_duty = $urandom_range(2000, 32767);
      end
      tick.motor_enabled   = ($urandom_range(99) < 92);
      tick.assist_mode     = run_mode;
      tick.pedaling        = ($urandom_range(99) < 90);
      tick.torque_fraction = ($urandom_range(99) < 70) ? 16'($urandom_range(0, 32768)) :
                                                         16'($urandom);
      tick.gear            = run_gear;
      case ($urandom_range(9))
         6: begin
            duty = int'($signed(16'($urandom)));
         end
         7: begin
            duty = $urandom_range(600, 720);
         end
         8: begin
            duty = -int'($urandom_range(1, 32768));
         end
         9: begin
            duty = $urandom_range(0, 2000);
         end
         default: begin
            duty = run_duty + $urandom_range(0, 400) - 200;
            if (duty > 32767) begin
               duty = 32767;
            end
         end
      endcase
      tick.duty_now = 16'(duty);
      return tick;
   endfunction

   // One register access: setup phase, access phase until pready, then idle phase.
   task automatic csr_access(bit is_write, acc_pkg::reg_index_type index, logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata       = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Writes a register, mirrors it into the predictor and reads it back.
   task automatic program_register(acc_pkg::reg_index_type index, longint value);
      logic [31:0]        wdata;
      logic [31:0]        rdata;
      logic signed [16:0] low_value;
      logic [31:0]        mask;
      mask  = (index == acc_pkg::REG_LIMIT_LOW) ? 32'h1FFFF : 32'hFFFF;
      wdata = 32'(value) & mask;
      csr_access(1'b1, index, wdata, rdata);
      if (index == acc_pkg::REG_LIMIT_LOW) begin
         low_value = wdata[16:0];
         limit_low = longint'(low_value);
      end else if (index == acc_pkg::REG_LIMIT_HIGH) begin
         limit_high = longint'(wdata[15:0]);
      end else begin
         gear_amps[int'(index) + 1] = longint'(wdata[15:0]);
      end
      csr_access(1'b0, index, 32'd0, rdata);
      if ((rdata & mask) != wdata) begin
         $error("register %s read back: expected %0h, actual %0h", index.name(), wdata,
                rdata & mask);
         error_count++;
      end
   endtask

   // Offers one request, with random idle cycles first, and records its command once taken.
   task automatic send_tick(tick_type tick, bit fixed, logic signed [16:0] fixed_command);
      logic signed [16:0] predicted;
      while (!steady && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_motor_enabled   <= tick.motor_enabled;
      req_assist_mode     <= tick.assist_mode;
      req_pedaling        <= tick.pedaling;
      req_torque_fraction <= tick.torque_fraction;
      req_gear            <= tick.gear;
      req_duty_now        <= tick.duty_now;
      do @(posedge clock); while (req_stall);
      predicted = next_current_command(tick);
      command_queue.push_back(fixed ? fixed_command : predicted);
      request_count++;
   endtask

   // Waits until every command has come back and the block has gone quiet.
   task automatic drain_commands();
      req_valid <= 1'b0;
      while (command_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_random_ticks(int count, bit pressure);
      for (int i = 0; i < count; i++) begin
         // Long receiver hold-off while requests keep coming, then a full pause.
         if (pressure && i == 20) begin
            hold_request = 1'b1;
         end
         if (pressure && i == 60) begin
            req_valid <= 1'b0;
            while (command_queue.size() != 0) begin
               @(posedge clock);
            end
         end
         send_tick(random_tick(), 1'b0, '0);
      end
   endtask

   // Programs one register setting: 0 extremes, 1 zero limits, otherwise random.
   task automatic program_setting(int setting);
      longint value;
      for (int i = 0; i < 8; i++) begin
         case (setting)
            0: begin
               value = (acc_pkg::reg_index_type'(i) == acc_pkg::REG_LIMIT_LOW) ? -65536 : 65535;
            end
            1: begin
               value = (i >= int'(acc_pkg::REG_LIMIT_LOW)) ? 0 :
                       longint'($urandom_range(0, 65535));
            end
            2: begin
               if (acc_pkg::reg_index_type'(i) == acc_pkg::REG_LIMIT_LOW) begin
                  value = -longint'($urandom_range(0, 65536));
               end else begin
                  value = $urandom_range(0, 65535);
               end
            end
            default: begin
               if (acc_pkg::reg_index_type'(i) == acc_pkg::REG_LIMIT_LOW) begin
                  value = -longint'($urandom_range(0, 20000));
               end else if (acc_pkg::reg_index_type'(i) == acc_pkg::REG_LIMIT_HIGH) begin
                  value = $urandom_range(1000, 20000);
               end else begin
                  value = $urandom_range(0, 4000);
               end
            end
         endcase
         program_register(acc_pkg::reg_index_type'(i), value);
      end
      setting_count++;
   endtask

   // Stimulus: reset, directed table, then random ticks under each register setting.
   initial begin
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_motor_enabled   = 1'b0;
      req_assist_mode     = MODE_NONE;
      req_pedaling        = 1'b0;
      req_torque_fraction = '0;
      req_gear            = '0;
      req_duty_now        = '0;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      error_count         = 0;
      request_count       = 0;
      setting_count       = 1;
      motor_off_count     = 0;
      clear_count         = 0;
      ramp_count          = 0;
      steady              = 1'b0;
      hold_request        = 1'b0;
      run_gear            = 3'd3;
      run_mode            = acc_pkg::MODE_PEDAL;
      run_duty            = 16000;
      for (int g = 1; g <= 6; g++) begin
         gear_amps[g] = longint'(acc_pkg::GEAR_RESET[g - 1]);
      end
      limit_low     = longint'(acc_pkg::LIMIT_LOW_RESET);
      limit_high    = longint'(acc_pkg::LIMIT_HIGH_RESET);
      filtered_amps = 0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_tick(directed_rows[i].tick, directed_rows[i].fixed, directed_rows[i].command);
      end
      run_random_ticks(RANDOM_TICKS, 1'b0);

      for (int setting = 0; setting < 4; setting++) begin
         drain_commands();
         program_setting(setting);
         // The extreme setting runs with no idling on either side.
         steady = (setting == 0);
         run_random_ticks(RANDOM_TICKS, setting == 2);
         steady = 1'b0;
      end

      drain_commands();
      $display("Covered %0d requests under %0d register settings: %0d with the motor off,",
               request_count, setting_count, motor_off_count);
      $display("%0d zero-target clears and %0d ramp-limited rises.", clear_count, ramp_count);
      if (error_count == 0 && command_queue.size() == 0) begin
         $display("assist_current_controller_top_test passed");
      end else begin
         $display("assist_current_controller_top_test failed");
      end
      $finish;
   end

   // Result side: random stall, a long hold-off on demand, and the command check.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            if (command_queue.size() == 0) begin
               $error("current_command %0d arrived with no request outstanding",
                      rsp_current_command);
               error_count++;
            end else begin
               logic signed [16:0] wanted;
               wanted = command_queue.pop_front();
               if (rsp_current_command !== wanted) begin
                  $error("current_command mismatch: expected %0d, actual %0d", wanted,
                         rsp_current_command);
                  error_count++;
               end
            end
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !steady && ($urandom_range(99) < 31);
         end
      end
   end

   // Watchdog on the whole run.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("assist_current_controller_top_test failed");
            $finish;
         end
      end
   end

endmodule

@@ sim.f @@
hw/rtl/acc_pkg.sv
hw/rtl/acc_csr.sv
hw/rtl/acc_div.sv
hw/rtl/assist_current_controller_top.sv
hw/rtl/acc_checker.sv
tb/assist_current_controller_top_test.sv
